FILE: src/accel_motion_autocalibrate_top_macros.svh
// Assertion macros shared by the accelerometer calibration block.
`ifndef ACCEL_MOTION_AUTOCALIBRATE_TOP_MACROS_SVH
`define ACCEL_MOTION_AUTOCALIBRATE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define AMAC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define AMAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/amac_pkg.sv
// Shared types and constants of the accelerometer calibration block.
package amac_pkg;

    localparam int AXIS_W = 20;
    localparam int SUM_W  = 40;
    localparam int ROOT_W = 20;
    localparam int CNT_W  = 4;

    typedef logic signed [AXIS_W-1:0] axis_t;
    typedef logic [SUM_W-1:0]         sum_t;
    typedef logic [ROOT_W-1:0]        root_t;
    typedef logic [CNT_W-1:0]         count_t;

    // 1 g squared, in (1/8192 g)^2
    localparam sum_t   ONE_G_SQ    = 40'd67108864;
    localparam count_t COUNT_LIMIT = 4'd9;

    // Top bit of the root search: highest even power of two below 2^SUM_W.
    localparam sum_t ROOT_FIRST_BIT = sum_t'(1) << (SUM_W - 2);

endpackage

FILE: src/amac_if.sv
// Sample and result channel interfaces of the accelerometer calibration block.
interface amac_sample_if;
    logic       valid;
    logic       ready;
    logic [7:0] x_low_byte;
    logic [7:0] x_high_byte;
    logic [7:0] y_low_byte;
    logic [7:0] y_high_byte;
    logic [7:0] z_low_byte;
    logic [7:0] z_high_byte;

    modport source (
        output valid, x_low_byte, x_high_byte, y_low_byte, y_high_byte,
               z_low_byte, z_high_byte,
        input  ready
    );
    modport sink (
        input  valid, x_low_byte, x_high_byte, y_low_byte, y_high_byte,
               z_low_byte, z_high_byte,
        output ready
    );
endinterface

interface amac_result_if;
    logic            valid;
    logic            ready;
    amac_pkg::axis_t accel_x;
    amac_pkg::axis_t accel_y;
    amac_pkg::axis_t accel_z;
    amac_pkg::root_t magnitude;
    logic            offset_captured;
    amac_pkg::count_t motion_count;

    modport source (
        output valid, accel_x, accel_y, accel_z, magnitude, offset_captured,
               motion_count,
        input  ready
    );
    modport sink (
        input  valid, accel_x, accel_y, accel_z, magnitude, offset_captured,
               motion_count,
        output ready
    );
endinterface

FILE: src/accel_motion_autocalibrate_top.sv
// Top level: accelerometer offset correction, magnitude and motion-driven recalibration.
//
// sample_ch carries one raw accelerometer item (six bytes, low byte first per axis);
// result_ch returns one item per sample: the offset-corrected axes in 1/8192 g, the
// floor magnitude, the capture flag and the motion count. cfg_we/cfg_wdata write the
// full-scale select, which shifts each raw axis left by 0..3.
// Each item goes from acceptance to result valid through the shared 20x20 multiplier for
// the sum of squares, the start of the root, the two-bits-per-step square root and the
// output register.
// sample_ch.ready is high only while the sequencer is idle, so one item is in work at
// a time and a new sample is taken only once the last item has left the sequencer.
// The result sits in an output register; a new sample is taken while it waits, and a
// finished item whose result cannot yet be handed over holds until result_ch.ready.
// Reset clears the offsets and the motion count and arms a capture, so the first
// sample after reset becomes the new offsets and is reported uncorrected and flagged.
// Eleven consecutive samples above 1 g arm a capture for the following sample.
`include "accel_motion_autocalibrate_top_macros.svh"

module accel_motion_autocalibrate_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_wdata,
    amac_sample_if.sink          sample_ch,
    amac_result_if.source        result_ch
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SQ   = 2'd1;
    localparam logic [1:0] ST_ROOT = 2'd2;
    localparam logic [1:0] ST_WAIT = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [1:0]        range_reg;
    amac_pkg::axis_t   off_x_reg, off_y_reg, off_z_reg;
    amac_pkg::axis_t   ax_reg, ay_reg, az_reg;
    amac_pkg::count_t  count_reg;
    logic              pending_reg;
    logic              captured_reg;

    logic              out_valid_reg;
    amac_pkg::axis_t   out_x_reg, out_y_reg, out_z_reg;
    amac_pkg::root_t   out_mag_reg;
    logic              out_cap_reg;
    amac_pkg::count_t  out_cnt_reg;

    logic              accept;
    logic              out_free;
    logic              load_out;
    amac_pkg::axis_t   sx, sy, sz;
    amac_pkg::sum_t    sum;
    logic              sum_done;
    amac_pkg::root_t   root;
    logic              root_done;

    function automatic amac_pkg::axis_t scale_axis(input logic [7:0] lo, input logic [7:0] hi,
                                                   input logic [1:0] shift);
        logic signed [15:0] raw;
        raw = {hi, lo};
        return amac_pkg::axis_t'(raw) <<< shift;
    endfunction

    assign accept   = sample_ch.valid && sample_ch.ready;
    assign out_free = !out_valid_reg || result_ch.ready;
    assign load_out = (state_reg == ST_WAIT) && out_free;

    assign sx = scale_axis(sample_ch.x_low_byte, sample_ch.x_high_byte, range_reg);
    assign sy = scale_axis(sample_ch.y_low_byte, sample_ch.y_high_byte, range_reg);
    assign sz = scale_axis(sample_ch.z_low_byte, sample_ch.z_high_byte, range_reg);

    amac_sumsq u_sumsq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .ax    (ax_reg),
        .ay    (ay_reg),
        .az    (az_reg),
        .sum   (sum),
        .done  (sum_done)
    );

    amac_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sum_done),
        .value (sum),
        .root  (root),
        .done  (root_done)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                if (sum_done)
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (root_done)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            range_reg     <= 2'd0;
            off_x_reg     <= '0;
            off_y_reg     <= '0;
            off_z_reg     <= '0;
            count_reg     <= '0;
            pending_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                range_reg <= cfg_wdata;
            end
            if (accept && pending_reg)
            begin
                off_x_reg   <= sx;
                off_y_reg   <= sy;
                off_z_reg   <= sz;
                pending_reg <= 1'b0;
            end
            // exact above-1g test on the sum, not on the floor root
            if (sum_done && (state_reg == ST_SQ))
            begin
                if (sum > amac_pkg::ONE_G_SQ)
                begin
                    if (count_reg > amac_pkg::COUNT_LIMIT)
                    begin
                        count_reg   <= '0;
                        pending_reg <= 1'b1;
                    end
                    else
                    begin
                        count_reg <= count_reg + amac_pkg::count_t'(1);
                    end
                end
                else
                begin
                    count_reg <= '0;
                end
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            captured_reg <= pending_reg;
            ax_reg <= pending_reg ? sx : sx - off_x_reg;
            ay_reg <= pending_reg ? sy : sy - off_y_reg;
            az_reg <= pending_reg ? sz : sz - off_z_reg;
        end
        if (load_out)
        begin
            out_x_reg   <= ax_reg;
            out_y_reg   <= ay_reg;
            out_z_reg   <= az_reg;
            out_mag_reg <= root;
            out_cap_reg <= captured_reg;
            out_cnt_reg <= count_reg;
        end
    end

    assign sample_ch.ready           = (state_reg == ST_IDLE);
    assign result_ch.valid           = out_valid_reg;
    assign result_ch.accel_x         = out_x_reg;
    assign result_ch.accel_y         = out_y_reg;
    assign result_ch.accel_z         = out_z_reg;
    assign result_ch.magnitude       = out_mag_reg;
    assign result_ch.offset_captured = out_cap_reg;
    assign result_ch.motion_count    = out_cnt_reg;

    `AMAC_ASSERT_NEXT(a_busy_after_accept, accept, !sample_ch.ready,
        "sample taken while an item is still in work")
    `AMAC_ASSERT_SAME(a_count_bound, result_ch.valid,
        result_ch.motion_count <= (amac_pkg::COUNT_LIMIT + amac_pkg::count_t'(1)),
        "motion count beyond its limit")
    `AMAC_ASSERT_SAME(a_zero_root, result_ch.valid && (result_ch.magnitude == '0),
        (result_ch.accel_x == '0) && (result_ch.accel_y == '0) && (result_ch.accel_z == '0),
        "zero magnitude with a non-zero axis")

endmodule

FILE: src/amac_sumsq.sv
// Sum of squares of three axes through one shared multiplier.
module amac_sumsq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  amac_pkg::axis_t ax,
    input  amac_pkg::axis_t ay,
    input  amac_pkg::axis_t az,
    output amac_pkg::sum_t  sum,
    output logic            done
);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [1:0]      idx_reg, idx_next;
    amac_pkg::sum_t  prod_reg, prod_next;
    amac_pkg::sum_t  acc_reg, acc_next;
    amac_pkg::axis_t operand;
    logic signed [amac_pkg::SUM_W-1:0] square;

    always_comb
    begin
        case (idx_reg)
            2'd0:    operand = ax;
            2'd1:    operand = ay;
            2'd2:    operand = az;
            default: operand = ax;
        endcase
    end

    assign square = operand * operand;

    // idx 0..2 multiply, idx 1..3 accumulate the previous product
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        idx_next  = idx_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            idx_next  = 2'd0;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            prod_next = amac_pkg::sum_t'(square);
            if (idx_reg != 2'd0)
            begin
                acc_next = acc_reg + prod_reg;
            end
            idx_next = idx_reg + 2'd1;
            if (idx_reg == 2'd3)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign sum  = acc_reg;
    assign done = done_reg;

endmodule

FILE: src/amac_isqrt.sv
// Iterative floor square root, two radicand bits per cycle.
module amac_isqrt (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  amac_pkg::sum_t  value,
    output amac_pkg::root_t root,
    output logic            done
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    amac_pkg::sum_t              rem_reg, rem_next;
    amac_pkg::sum_t              bit_reg, bit_next;
    logic [amac_pkg::SUM_W:0]    res_reg, res_next;
    logic [amac_pkg::SUM_W:0]    trial;

    assign trial = res_reg + {1'b0, bit_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        bit_next  = bit_reg;
        res_next  = res_reg;
        if (start)
        begin
            busy_next = 1'b1;
            rem_next  = value;
            bit_next  = amac_pkg::ROOT_FIRST_BIT;
            res_next  = '0;
        end
        else if (busy_reg)
        begin
            if ({1'b0, rem_reg} >= trial)
            begin
                rem_next = rem_reg - trial[amac_pkg::SUM_W-1:0];
                res_next = (res_reg >> 1) + {1'b0, bit_reg};
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        bit_reg <= bit_next;
        res_reg <= res_next;
    end

    assign root = res_reg[amac_pkg::ROOT_W-1:0];
    assign done = done_reg;

endmodule

FILE: tb/sv/amac_calibration_checker.sv
// Checker for the accelerometer calibration block: predicts every result item and compares it.
module amac_calibration_checker
    import amac_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,
    amac_sample_if     sample_ch,
    amac_result_if     result_ch,
    output int         fail_count,
    output int         outstanding,
    output int         n_checked,
    output int         n_captured
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned ONE_G_SQUARED = 64'd67108864;
    localparam int              MOTION_LIMIT  = 9;
    localparam int              MAX_REPORTS   = 10;

    typedef struct packed {
        axis_t  ax;
        axis_t  ay;
        axis_t  az;
        root_t  mag;
        logic   captured;
        count_t motion;
    } calib_result_t;

    // predictor state
    logic [1:0] scale_shift;
    int         base_x;
    int         base_y;
    int         base_z;
    int         run_len;
    logic       recapture;

    calib_result_t calibrated_q[$];

    // raw axis is low byte first, two's complement, then scaled to 1/8192 g
    function automatic int scaled_axis(input logic [7:0] lo, input logic [7:0] hi);
        logic signed [15:0] raw;
        raw = {hi, lo};
        return int'(raw) <<< scale_shift;
    endfunction

    function automatic root_t floor_root(input longint unsigned v);
        longint unsigned r;
        longint unsigned trial;
        r = 0;
        for (int b = ROOT_W - 1; b >= 0; b--)
        begin
            trial = r | (64'd1 << b);
            if (trial * trial <= v)
                r = trial;
        end
        return root_t'(r);
    endfunction

    function automatic calib_result_t predict_calibrated(
        input logic [7:0] xl, input logic [7:0] xh,
        input logic [7:0] yl, input logic [7:0] yh,
        input logic [7:0] zl, input logic [7:0] zh
    );
        int              sx;
        int              sy;
        int              sz;
        int              ax;
        int              ay;
        int              az;
        longint unsigned energy;
        calib_result_t   r;
        sx = scaled_axis(xl, xh);
        sy = scaled_axis(yl, yh);
        sz = scaled_axis(zl, zh);
        r.captured = recapture;
        if (recapture)
        begin
            // capture item: reported uncorrected, becomes the new offsets
            base_x    = sx;
            base_y    = sy;
            base_z    = sz;
            ax        = sx;
            ay        = sy;
            az        = sz;
            recapture = 1'b0;
        end
        else
        begin
            ax = sx - base_x;
            ay = sy - base_y;
            az = sz - base_z;
        end
        energy = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
        // exact test on the sum of squares, not on the rounded root
        if (energy > ONE_G_SQUARED)
        begin
            if (run_len > MOTION_LIMIT)
            begin
                run_len   = 0;
                recapture = 1'b1;
            end
            else
                run_len = run_len + 1;
        end
        else
            run_len = 0;
        r.ax     = axis_t'(ax);
        r.ay     = axis_t'(ay);
        r.az     = axis_t'(az);
        r.mag    = floor_root(energy);
        r.motion = count_t'(run_len);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        calib_result_t want;
        calib_result_t got;
        if (!rst_n)
        begin
            scale_shift = '0;
            base_x      = 0;
            base_y      = 0;
            base_z      = 0;
            run_len     = 0;
            recapture   = 1'b1;
            calibrated_q.delete();
            fail_count  <= 0;
            outstanding <= 0;
            n_checked   <= 0;
            n_captured  <= 0;
        end
        else
        begin
            // results first, so an item accepted in the same cycle cannot mask a stray result
            if (result_ch.valid && result_ch.ready)
            begin
                got = '{result_ch.accel_x, result_ch.accel_y, result_ch.accel_z,
                        result_ch.magnitude, result_ch.offset_captured,
                        result_ch.motion_count};
                if (calibrated_q.size() == 0)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display("result item with nothing predicted: x=%0d y=%0d z=%0d",
                                 got.ax, got.ay, got.az);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = calibrated_q.pop_front();
                    n_checked <= n_checked + 1;
                    if (want.captured)
                        n_captured <= n_captured + 1;
                    if (got !== want)
                    begin
                        if (fail_count < MAX_REPORTS)
                            $display({"mismatch on result %0d: ",
                                      "expected x=%0d y=%0d z=%0d mag=%0d cap=%0b cnt=%0d, ",
                                      "got x=%0d y=%0d z=%0d mag=%0d cap=%0b cnt=%0d"},
                                     n_checked, want.ax, want.ay, want.az, want.mag,
                                     want.captured, want.motion, got.ax, got.ay, got.az,
                                     got.mag, got.captured, got.motion);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (sample_ch.valid && sample_ch.ready)
                calibrated_q.push_back(predict_calibrated(
                    sample_ch.x_low_byte, sample_ch.x_high_byte,
                    sample_ch.y_low_byte, sample_ch.y_high_byte,
                    sample_ch.z_low_byte, sample_ch.z_high_byte));
            if (cfg_we)
                scale_shift = cfg_wdata;
            outstanding <= calibrated_q.size();
        end
    end

endmodule

FILE: tb/sv/accel_motion_autocalibrate_top_test.sv
// Testbench top: clock, reset, sample and result traffic, range writes and the verdict.
module accel_motion_autocalibrate_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import amac_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 40;
    localparam int PHASES          = 12;
    localparam int PHASE_ITEMS     = 150;
    localparam logic [1:0] RANGE_ORDER [6] = '{2'd3, 2'd0, 2'd2, 2'd1, 2'd3, 2'd0};

    logic       clk   = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we;
    logic [1:0] cfg_wdata;

    int         fail_count;
    int         outstanding;
    int         n_checked;
    int         n_captured;
    int         n_sent;
    logic [3:0] ranges_used;
    logic [1:0] cur_range;
    logic       sender_eager;

    amac_sample_if sample_ch ();
    amac_result_if result_ch ();

    accel_motion_autocalibrate_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .sample_ch (sample_ch),
        .result_ch (result_ch)
    );

    amac_calibration_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .sample_ch   (sample_ch),
        .result_ch   (result_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .n_checked   (n_checked),
        .n_captured  (n_captured)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 15);
        return $urandom_range(30, 90);
    endfunction

    function automatic shortint random_word();
        return shortint'($urandom_range(0, 65535));
    endfunction

    function automatic shortint nudge(input shortint v, input int d);
        return shortint'(int'(v) + d);
    endfunction

    // valid is left high after the item goes; the next call lowers it only for a gap
    task automatic offer_sample(input shortint x, input shortint y, input shortint z);
        int gap;
        gap = sender_eager ? 0 : idle_gap();
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid       <= 1'b1;
        sample_ch.x_low_byte  <= x[7:0];
        sample_ch.x_high_byte <= x[15:8];
        sample_ch.y_low_byte  <= y[7:0];
        sample_ch.y_high_byte <= y[15:8];
        sample_ch.z_low_byte  <= z[7:0];
        sample_ch.z_high_byte <= z[15:8];
        do @(posedge clk); while (!sample_ch.ready);
        n_sent++;
    endtask

    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_range(input logic [1:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_range = value;
        ranges_used[value] = 1'b1;
    endtask

    // a run of motion, then rest items around a rest vector; a run of eleven or more
    // arms a capture, so the item after the eleventh usually becomes the new offsets
    task automatic motion_phase(input int n_items);
        shortint rest_x;
        shortint rest_y;
        shortint rest_z;
        int      one_g_raw;
        int      burst;
        int      quiet;
        int      step;
        int      roll;
        int      done;
        one_g_raw = 8192 >> cur_range;
        done = 0;
        while (done < n_items)
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    rest_x = random_word();
                    rest_y = random_word();
                    rest_z = random_word();
                end
                1:
                begin
                    rest_x = shortint'(int'($urandom_range(0, 4000)) - 2000);
                    rest_y = shortint'(int'($urandom_range(0, 4000)) - 2000);
                    rest_z = shortint'(int'($urandom_range(0, 4000)) - 2000);
                end
                default:
                begin
                    rest_x = shortint'(int'($urandom_range(0, 400)) - 200);
                    rest_y = shortint'(int'($urandom_range(0, 400)) - 200);
                    rest_z = shortint'(one_g_raw + int'($urandom_range(0, 20)) - 10);
                end
            endcase
            burst = $urandom_range(0, 1) ? $urandom_range(11, 13) : $urandom_range(0, 10);
            repeat (burst)
            begin
                offer_sample(random_word(), random_word(), random_word());
                done++;
            end
            quiet = $urandom_range(1, 8);
            repeat (quiet)
            begin
                roll = $urandom_range(0, 9);
                if (roll < 2)
                    offer_sample(rest_x, rest_y, rest_z);
                else if (roll < 4)
                begin
                    // straddles the 1 g threshold along z
                    step = one_g_raw + int'($urandom_range(0, 2)) - 1;
                    offer_sample(rest_x, rest_y,
                                 nudge(rest_z, $urandom_range(0, 1) ? step : -step));
                end
                else
                    offer_sample(nudge(rest_x, int'($urandom_range(0, 6)) - 3),
                                 nudge(rest_y, int'($urandom_range(0, 6)) - 3),
                                 nudge(rest_z, int'($urandom_range(0, 6)) - 3));
                done++;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                offer_sample(random_word(), random_word(), random_word());
                done++;
            end
        end
    endtask

    initial
    begin
        cfg_we                <= 1'b0;
        cfg_wdata             <= '0;
        sample_ch.valid       <= 1'b0;
        sample_ch.x_low_byte  <= '0;
        sample_ch.x_high_byte <= '0;
        sample_ch.y_low_byte  <= '0;
        sample_ch.y_high_byte <= '0;
        sample_ch.z_low_byte  <= '0;
        sample_ch.z_high_byte <= '0;
        n_sent       = 0;
        ranges_used  = 4'b0001;
        cur_range    = 2'd0;
        sender_eager = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first item after reset is captured as the offsets
        offer_sample(0, 0, 0);
        // exactly 1 g is not above 1 g; one more count is
        offer_sample(0, 0, 8192);
        offer_sample(0, 0, 8193);
        offer_sample(32767, -32768, 32767);
        offer_sample(-1, -1, -1);
        // byte order: 0x8001, 0x00ff, 0xff00
        offer_sample(-32767, 255, -256);
        // with the item before, these reach eleven above 1 g in a row and arm a capture of the last one
        repeat (11) offer_sample(0, 0, 16384);
        offer_sample(16'sh1234, -16'sh0567, 16'sh2000);
        offer_sample(16'sh1234, -16'sh0567, 16'sh2000);
        offer_sample(16'sh1234, -16'sh0567, 16'sh4000);
        offer_sample(-32768, -32768, -32768);

        for (int p = 0; p < PHASES; p++)
        begin
            write_range(p < 6 ? RANGE_ORDER[p] : 2'($urandom_range(0, 3)));
            sender_eager = ($urandom_range(0, 4) == 0);
            motion_phase(PHASE_ITEMS);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Checked %0d of %0d samples over range settings %b, %0d offset captures.",
                 n_checked, n_sent, ranges_used, n_captured);
        if (fail_count == 0 && outstanding == 0)
            $display("accel_motion_autocalibrate_top_test: PASS");
        else
            $display("accel_motion_autocalibrate_top_test: FAIL");
        $finish;
    end

    // result side: random stalls, eager stretches and a few long hold-offs
    initial
    begin
        int   taken;
        int   stall;
        logic eager;
        result_ch.ready <= 1'b0;
        taken = 0;
        eager = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (taken % 100 == 0)
                eager = ($urandom_range(0, 3) == 0);
            if (taken == 250 || taken == 900 || taken == 1500)
                stall = HOLD_OFF_CYCLES;
            else
                stall = eager ? 0 : idle_gap();
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
            taken++;
        end
    end

    // ends the run if no item moves on either channel for too long
    initial
    begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("accel_motion_autocalibrate_top_test: FAIL");
        $finish;
    end

endmodule
